[rtl/fsc_pkg.sv]
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types, widths and plane tables of the frustum sphere cull unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

  localparam int NumPlanes = 6;
  localparam int ElemW     = 32;             // Q16.16 matrix and center values
  localparam int RawW      = ElemW + 1;      // exact plane term sums
  localparam int MagW      = RawW;           // magnitudes of plane terms
  localparam int NormBits  = 30;             // Q2.30 normal components
  localparam int FracBits  = 16;
  localparam int M3W       = MagW + 29;      // distance magnitude after scaling
  localparam int SumW      = 2 * NormBits + 2;
  localparam int LenW      = SumW / 2;
  localparam int NumW      = M3W + FracBits; // divider numerator
  localparam int RadW      = 31;

  typedef logic [2:0] plane_idx_t;
  typedef logic [1:0] row_idx_t;

  localparam plane_idx_t LastPlane = plane_idx_t'(NumPlanes - 1);

  typedef enum logic [1:0] {
    OP_WRITE_ROW = 2'd0,
    OP_EXTRACT   = 2'd1,
    OP_SPHERE    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_SUB,
    MODE_ADD,
    MODE_ONLY
  } plane_mode_e;

  // Matrix row write request
  typedef struct packed {
    logic     en;
    row_idx_t row;
  } row_wr_t;

  // Plane store write request
  typedef struct packed {
    logic       en;
    plane_idx_t addr;
    logic       degenerate;
  } plane_wr_t;

  // Column combined with column four for each plane (used alone for the near plane)
  function automatic logic [1:0] plane_col(plane_idx_t p);
    logic [1:0] c;
    unique case (p)
      3'd0, 3'd1: c = 2'd0;
      3'd2, 3'd3: c = 2'd1;
      default:    c = 2'd2;
    endcase
    return c;
  endfunction

  // Right, left, bottom, top, far, near
  function automatic plane_mode_e plane_mode(plane_idx_t p);
    plane_mode_e m;
    unique case (p)
      3'd0:    m = MODE_SUB;
      3'd1:    m = MODE_ADD;
      3'd2:    m = MODE_ADD;
      3'd3:    m = MODE_SUB;
      3'd4:    m = MODE_SUB;
      default: m = MODE_ONLY;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/fsc_div.sv]
// ----------------------------------------------------------------------------
// fsc_div
// Restoring divider, one quotient bit per cycle, with overflow detection.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_div #(
  parameter int NUM_W = 78,
  parameter int DEN_W = 31,
  parameter int QUO_W = 31
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [QUO_W-1:0]      quo_o,
  output logic                  ovf_o
);

  localparam int CntW = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [DEN_W-1:0] den_q;
  logic [CntW-1:0]  cnt_q;
  logic             run_q;
  logic             done_q;
  logic             ovf_q;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [NUM_W-1:0] top;

  // Compare the partial remainder with the divisor
  assign top   = num_i >> QUO_W;
  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  // Shift one quotient bit in per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(QUO_W);
        ovf_q <= top >= NUM_W'(den_i);
        rem_q <= DEN_W'(top);
        quo_q <= num_i[QUO_W-1:0];
        den_q <= den_i;
      end else if (run_q) begin
        rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
        quo_q <= {quo_q[QUO_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q;

endmodule

`default_nettype wire

[rtl/fsc_isqrt.sv]
// ----------------------------------------------------------------------------
// fsc_isqrt
// Floor square root, one root bit per cycle, digit by digit.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_isqrt #(
  parameter int RAD_W = 62
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [RAD_W-1:0]   rad_i,
  output logic                    done_o,
  output logic [RAD_W/2-1:0]      root_o
);

  localparam int RootW = RAD_W / 2;
  localparam int RemW  = RootW + 3;
  localparam int CntW  = $clog2(RootW + 1);

  logic [RAD_W-1:0] rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [CntW-1:0]  cnt_q;
  logic             run_q;
  logic             done_q;

  logic [RemW-1:0]  cur;
  logic [RemW-1:0]  trial;
  logic             ge;

  // Bring in two radicand bits and try the next root bit
  assign cur   = {rem_q[RemW-3:0], rad_q[RAD_W-1:RAD_W-2]};
  assign trial = RemW'({root_q, 2'b01});
  assign ge    = cur >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        cnt_q  <= CntW'(RootW);
        rad_q  <= rad_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (run_q) begin
        rad_q  <= rad_q << 2;
        rem_q  <= ge ? cur - trial : cur;
        root_q <= {root_q[RootW-2:0], ge};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

[rtl/fsc_extract.sv]
// ----------------------------------------------------------------------------
// fsc_extract
// Clip matrix store and plane extraction sequencer: forms, scales and
// normalizes six planes and writes them to the plane store.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_extract #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire fsc_pkg::row_wr_t            row_wr_i,
  input  wire logic [3:0][31:0]            row_data_i,
  input  wire logic                        start_i,
  output logic                             busy_o,
  output fsc_pkg::plane_wr_t               pw_o,
  output logic [2:0][31:0]                 pw_normal_o,
  output logic [VALUE_WIDTH-1:0]           pw_dist_o
);

  import fsc_pkg::*;

  localparam int QuoW = (VALUE_WIDTH - 1 > LenW) ? VALUE_WIDTH - 1 : LenW;
  localparam logic [VALUE_WIDTH-1:0] DistLim = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  typedef enum logic [3:0] {
    E_IDLE, E_READ, E_RAW, E_MAG, E_NORM, E_SQ,
    E_SQRT_GO, E_SQRT_WAIT, E_DIV_GO, E_DIV_WAIT, E_WRITE
  } ext_state_e;

  // Clip matrix memory, one row per entry
  logic [3:0][ElemW-1:0] mat_mem [4];
  logic [3:0]            row_valid_q;
  logic [3:0][ElemW-1:0] rd_data_q;
  logic                  rd_valid_q;

  ext_state_e              state_q;
  plane_idx_t              p_q;
  logic [1:0]              k_q;
  logic [1:0]              j_q;
  logic signed [RawW-1:0]  raw_q [4];
  logic [MagW-1:0]         m_q [3];
  logic [M3W-1:0]          m3_q;
  logic [2*NormBits-1:0]   prod_q;
  logic [SumW-1:0]         sum_q;
  logic [LenW-1:0]         len_q;
  logic [2:0][ElemW-1:0]   n_q;
  logic [VALUE_WIDTH-1:0]  dist_q;
  logic                    deg_q;

  logic signed [RawW-1:0]  a_term;
  logic signed [RawW-1:0]  b_term;
  logic signed [RawW-1:0]  raw_d;
  logic [MagW-1:0]         mag [4];
  logic [MagW-1:0]         mx_in;
  logic [MagW-1:0]         mx;
  logic [NormBits-1:0]     sq_in;
  logic [NumW-1:0]         div_num;
  logic                    div_done;
  logic [QuoW-1:0]         div_quo;
  logic                    div_ovf;
  logic                    sqrt_done;
  logic [LenW-1:0]         sqrt_root;
  logic [ElemW-1:0]        nmag;
  logic [VALUE_WIDTH-1:0]  dmag;

  // Write rows, read the row of the current step
  always_ff @(posedge clk_i) begin
    if (row_wr_i.en) begin
      mat_mem[row_wr_i.row] <= row_data_i;
    end
    rd_data_q  <= mat_mem[k_q];
    rd_valid_q <= row_valid_q[k_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (row_wr_i.en) begin
      row_valid_q[row_wr_i.row] <= 1'b1;
    end
  end

  // Form one raw plane term from the row just read
  always_comb begin
    a_term = rd_valid_q ? RawW'($signed(rd_data_q[3])) : '0;
    b_term = rd_valid_q ? RawW'($signed(rd_data_q[plane_col(p_q)])) : '0;
    unique case (plane_mode(p_q))
      MODE_SUB: raw_d = a_term - b_term;
      MODE_ADD: raw_d = a_term + b_term;
      default:  raw_d = b_term;
    endcase
  end

  // Magnitudes and the largest normal magnitude
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = raw_q[i][RawW-1] ? MagW'(-raw_q[i]) : MagW'(raw_q[i]);
    end
    mx_in = (mag[0] > mag[1]) ? mag[0] : mag[1];
    mx_in = (mx_in > mag[2]) ? mx_in : mag[2];
    mx    = (m_q[0] > m_q[1]) ? m_q[0] : m_q[1];
    mx    = (mx > m_q[2]) ? mx : m_q[2];
  end

  // Select the squaring operand and the divider numerator
  always_comb begin
    unique case (j_q)
      2'd0:    sq_in = m_q[0][NormBits-1:0];
      2'd1:    sq_in = m_q[1][NormBits-1:0];
      2'd2:    sq_in = m_q[2][NormBits-1:0];
      default: sq_in = '0;
    endcase
    unique case (j_q)
      2'd0:    div_num = NumW'({m_q[0][NormBits-1:0], {NormBits{1'b0}}});
      2'd1:    div_num = NumW'({m_q[1][NormBits-1:0], {NormBits{1'b0}}});
      2'd2:    div_num = NumW'({m_q[2][NormBits-1:0], {NormBits{1'b0}}});
      default: div_num = {m3_q, {FracBits{1'b0}}};
    endcase
  end

  // Normal magnitude and saturated distance magnitude
  assign nmag = {1'b0, div_quo[ElemW-2:0]};
  assign dmag = (div_ovf || (div_quo > QuoW'(DistLim))) ? DistLim
                                                         : VALUE_WIDTH'(div_quo);

  fsc_isqrt #(
    .RAD_W (SumW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == E_SQRT_GO),
    .rad_i   (sum_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  fsc_div #(
    .NUM_W (NumW),
    .DEN_W (LenW),
    .QUO_W (QuoW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == E_DIV_GO),
    .num_i   (div_num),
    .den_i   (len_q),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .ovf_o   (div_ovf)
  );

  // Sequence reads, scaling, root and divisions for each plane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      p_q     <= '0;
      k_q     <= '0;
      j_q     <= '0;
      deg_q   <= 1'b0;
      for (int i = 0; i < 4; i++) raw_q[i] <= '0;
      for (int i = 0; i < 3; i++) m_q[i] <= '0;
      m3_q    <= '0;
      prod_q  <= '0;
      sum_q   <= '0;
      len_q   <= '0;
      n_q     <= '0;
      dist_q  <= '0;
    end else begin
      unique case (state_q)
        E_IDLE: begin
          if (start_i) begin
            p_q     <= '0;
            k_q     <= '0;
            state_q <= E_READ;
          end
        end
        E_READ: begin
          state_q <= E_RAW;
        end
        E_RAW: begin
          raw_q[k_q] <= raw_d;
          if (k_q == 2'd3) begin
            state_q <= E_MAG;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= E_READ;
          end
        end
        E_MAG: begin
          for (int i = 0; i < 3; i++) m_q[i] <= mag[i];
          m3_q <= M3W'(mag[3]);
          if (mx_in == '0) begin
            deg_q   <= 1'b1;
            state_q <= E_WRITE;
          end else begin
            deg_q   <= 1'b0;
            state_q <= E_NORM;
          end
        end
        E_NORM: begin
          if (mx[MagW-1:NormBits] != '0) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
            m3_q <= m3_q >> 1;
          end else if (!mx[NormBits-1]) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
            m3_q <= m3_q << 1;
          end else begin
            j_q     <= '0;
            prod_q  <= '0;
            sum_q   <= '0;
            state_q <= E_SQ;
          end
        end
        E_SQ: begin
          prod_q <= sq_in * sq_in;
          sum_q  <= sum_q + SumW'(prod_q);
          if (j_q == 2'd3) begin
            state_q <= E_SQRT_GO;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        E_SQRT_GO: begin
          state_q <= E_SQRT_WAIT;
        end
        E_SQRT_WAIT: begin
          if (sqrt_done) begin
            len_q   <= sqrt_root;
            j_q     <= '0;
            state_q <= E_DIV_GO;
          end
        end
        E_DIV_GO: begin
          state_q <= E_DIV_WAIT;
        end
        E_DIV_WAIT: begin
          if (div_done) begin
            if (j_q == 2'd3) begin
              dist_q  <= raw_q[3][RawW-1] ? VALUE_WIDTH'(-dmag) : dmag;
              state_q <= E_WRITE;
            end else begin
              n_q[j_q] <= raw_q[j_q][RawW-1] ? ElemW'(-nmag) : nmag;
              j_q      <= j_q + 1'b1;
              state_q  <= E_DIV_GO;
            end
          end
        end
        E_WRITE: begin
          if (p_q == LastPlane) begin
            state_q <= E_IDLE;
          end else begin
            p_q     <= p_q + 1'b1;
            k_q     <= '0;
            state_q <= E_READ;
          end
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  assign busy_o          = state_q != E_IDLE;
  assign pw_o.en         = state_q == E_WRITE;
  assign pw_o.addr       = p_q;
  assign pw_o.degenerate = deg_q;
  assign pw_normal_o     = n_q;
  assign pw_dist_o       = dist_q;

endmodule

`default_nettype wire

[rtl/fsc_sphere_test.sv]
// ----------------------------------------------------------------------------
// fsc_sphere_test
// Plane store and sphere test sequencer: one shared multiply-accumulate
// sweeps the planes and stops at the first plane that culls.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_sphere_test #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [2:0][31:0]       center_i,
  input  wire logic [30:0]            radius_i,
  input  wire fsc_pkg::plane_wr_t     pw_i,
  input  wire logic [2:0][31:0]       pw_normal_i,
  input  wire logic [VALUE_WIDTH-1:0] pw_dist_i,
  output logic                        busy_o,
  output logic                        res_valid_o,
  output logic                        res_visible_o
);

  import fsc_pkg::*;

  localparam int ProdW = 2 * ElemW;
  localparam int AccW  = ProdW + 2;
  localparam int SumRW = ((VALUE_WIDTH > ElemW) ? VALUE_WIDTH : ElemW) + 1;
  localparam int CmpW  = SumRW + NormBits + 6;

  typedef enum logic [2:0] {
    T_IDLE, T_READ, T_MUL, T_ADD, T_CHK
  } tst_state_e;

  // Plane store
  logic [2:0][ElemW-1:0]  nrm_mem [NumPlanes];
  logic [VALUE_WIDTH-1:0] dst_mem [NumPlanes];
  logic                   deg_mem [NumPlanes];
  logic [NumPlanes-1:0]   valid_q;
  logic [2:0][ElemW-1:0]  rd_nrm_q;
  logic [VALUE_WIDTH-1:0] rd_dst_q;
  logic                   rd_deg_q;

  tst_state_e             state_q;
  plane_idx_t             p_q;
  logic [1:0]             cnt_q;
  logic [2:0][ElemW-1:0]  c_q;
  logic [RadW-1:0]        r_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0] acc_q;
  logic                   res_valid_q;
  logic                   res_visible_q;

  logic signed [ProdW-1:0] mul;
  logic signed [SumRW-1:0] dr;
  logic signed [CmpW-1:0]  lhs;
  logic                    cull;

  // Write planes, read the plane under test
  always_ff @(posedge clk_i) begin
    if (pw_i.en) begin
      nrm_mem[pw_i.addr] <= pw_normal_i;
      dst_mem[pw_i.addr] <= pw_dist_i;
      deg_mem[pw_i.addr] <= pw_i.degenerate;
    end
    rd_nrm_q <= nrm_mem[p_q];
    rd_dst_q <= dst_mem[p_q];
    rd_deg_q <= !valid_q[p_q] || deg_mem[p_q];
  end

  // Unwritten planes read as degenerate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (pw_i.en) begin
      valid_q[pw_i.addr] <= 1'b1;
    end
  end

  // Product of one normal component and one center coordinate
  assign mul = $signed(rd_nrm_q[cnt_q]) * $signed(c_q[cnt_q]);

  // Cull when dot + (d + r) * 2^30 <= 0
  assign dr   = SumRW'($signed(rd_dst_q)) + SumRW'($signed({1'b0, r_q}));
  assign lhs  = CmpW'(acc_q) + (CmpW'(dr) <<< NormBits);
  assign cull = !rd_deg_q && (lhs <= 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= T_IDLE;
      p_q           <= '0;
      cnt_q         <= '0;
      c_q           <= '0;
      r_q           <= '0;
      prod_q        <= '0;
      acc_q         <= '0;
      res_valid_q   <= 1'b0;
      res_visible_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        T_IDLE: begin
          if (start_i) begin
            c_q     <= center_i;
            r_q     <= radius_i;
            p_q     <= '0;
            state_q <= T_READ;
          end
        end
        T_READ: begin
          acc_q   <= '0;
          prod_q  <= '0;
          cnt_q   <= '0;
          state_q <= T_MUL;
        end
        T_MUL: begin
          prod_q <= mul;
          acc_q  <= acc_q + AccW'(prod_q);
          if (cnt_q == 2'd2) begin
            state_q <= T_ADD;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        T_ADD: begin
          acc_q   <= acc_q + AccW'(prod_q);
          state_q <= T_CHK;
        end
        T_CHK: begin
          if (cull) begin
            res_valid_q   <= 1'b1;
            res_visible_q <= 1'b0;
            state_q       <= T_IDLE;
          end else if (p_q == LastPlane) begin
            res_valid_q   <= 1'b1;
            res_visible_q <= 1'b1;
            state_q       <= T_IDLE;
          end else begin
            p_q     <= p_q + 1'b1;
            state_q <= T_READ;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign busy_o        = state_q != T_IDLE;
  assign res_valid_o   = res_valid_q;
  assign res_visible_o = res_visible_q;

endmodule

`default_nettype wire

[rtl/frustum_sphere_cull_unit.sv]
// ----------------------------------------------------------------------------
// frustum_sphere_cull_unit
// Clip matrix rows, frustum plane extraction and sphere visibility tests.
// ----------------------------------------------------------------------------
// Matrix row write: written in the cycle it is accepted, busy stays low.
// Sphere test: per plane, plane store read, three passes through one
//   shared multiplier, accumulate, compare; valid_o strobes early on the first
//   culling plane, else after the last plane. One test at a time.
// Extraction: runs a serial root and four serial divisions per plane.
// Reset: matrix reads as zero and all planes as degenerate (visible).
`default_nettype none

module frustum_sphere_cull_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op_i,
  input  wire logic [1:0]  row_index_i,
  input  wire logic [31:0] row_elem_0_i,
  input  wire logic [31:0] row_elem_1_i,
  input  wire logic [31:0] row_elem_2_i,
  input  wire logic [31:0] row_elem_3_i,
  input  wire logic [31:0] center_x_i,
  input  wire logic [31:0] center_y_i,
  input  wire logic [31:0] center_z_i,
  input  wire logic [30:0] radius_i,
  output logic             valid_o,
  output logic             visible_o
);

  import fsc_pkg::*;

  logic                   accept;
  logic                   ext_busy;
  logic                   tst_busy;
  logic                   ext_start;
  logic                   tst_start;
  row_wr_t                row_wr;
  plane_wr_t              pw;
  logic [2:0][31:0]       pw_normal;
  logic [VALUE_WIDTH-1:0] pw_dist;

  // Decode the accepted item
  assign accept     = start && !busy;
  assign row_wr.en  = accept && (op_i == OP_WRITE_ROW);
  assign row_wr.row = row_index_i;
  assign ext_start  = accept && (op_i == OP_EXTRACT);
  assign tst_start  = accept && (op_i == OP_SPHERE);
  assign busy       = ext_busy || tst_busy;

  fsc_extract #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_extract (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_wr_i    (row_wr),
    .row_data_i  ({row_elem_3_i, row_elem_2_i, row_elem_1_i, row_elem_0_i}),
    .start_i     (ext_start),
    .busy_o      (ext_busy),
    .pw_o        (pw),
    .pw_normal_o (pw_normal),
    .pw_dist_o   (pw_dist)
  );

  fsc_sphere_test #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_test (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (tst_start),
    .center_i      ({center_z_i, center_y_i, center_x_i}),
    .radius_i      (radius_i),
    .pw_i          (pw),
    .pw_normal_i   (pw_normal),
    .pw_dist_i     (pw_dist),
    .busy_o        (tst_busy),
    .res_valid_o   (valid_o),
    .res_visible_o (visible_o)
  );

  // Extraction and sphere test never run together
  a_engines_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ext_busy && tst_busy))
    else $error("extraction and sphere test overlap");

  // A result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  // An accepted test or extraction makes the unit busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ext_start || tst_start) |=> busy)
    else $error("accepted item did not start an engine");

  // Planes are written only while extraction runs
  a_plane_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pw.en |-> ext_busy && !tst_busy)
    else $error("plane store written outside extraction");

endmodule

`default_nettype wire

[dv/tb_frustum_sphere_cull_unit.sv]
// ----------------------------------------------------------------------------
// tb_frustum_sphere_cull_unit
// Self-checking regression of the frustum sphere cull unit: matrix row
// writes, plane extraction and sphere tests checked against a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_frustum_sphere_cull_unit;
  import fsc_pkg::*;

  localparam logic [1:0] OpUnused     = 2'd3;
  localparam int         IdleLimit    = 20000;
  localparam int         DrainCycles  = 60;
  localparam longint     Unit         = 64'sd1 << NormBits;
  localparam longint unsigned DistLim = (64'd1 << 31) - 1;

  typedef struct {
    logic [1:0]  op;
    logic [1:0]  row;
    logic [31:0] elem [4];
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [30:0] rad;
  } cmd_t;

  typedef longint quad_t [4];

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  op_i;
  logic [1:0]  row_index_i;
  logic [31:0] row_elem_0_i, row_elem_1_i, row_elem_2_i, row_elem_3_i;
  logic [31:0] center_x_i, center_y_i, center_z_i;
  logic [30:0] radius_i;
  logic        valid_o;
  logic        visible_o;

  // Predictor state
  int          clip_cells [16];
  int          plane_norm [NumPlanes][3];
  longint      plane_ofs  [NumPlanes];
  bit          plane_flat [NumPlanes];
  bit          visible_q [$];
  int          mismatches;
  int          idle_pct;
  int          idle_cnt;

  frustum_sphere_cull_unit i_dut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .row_index_i,
    .row_elem_0_i, .row_elem_1_i, .row_elem_2_i, .row_elem_3_i,
    .center_x_i, .center_y_i, .center_z_i, .radius_i, .valid_o, .visible_o
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void build_frustum_plane(int p, quad_t raw);
    longint unsigned m [4];
    longint unsigned mx, len, q, rem, dmag;
    longint n;
    mx = 0;
    for (int i = 0; i < 4; i++) m[i] = raw[i] < 0 ? longint'(-raw[i]) : raw[i];
    for (int i = 0; i < 3; i++) if (m[i] > mx) mx = m[i];
    if (mx == 0) begin
      plane_flat[p] = 1'b1;
      for (int i = 0; i < 3; i++) plane_norm[p][i] = 0;
      plane_ofs[p] = 0;
      return;
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 4; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 4; i++) m[i] <<= 1;
      mx <<= 1;
    end
    len = floor_root(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      n = longint'((m[i] << NormBits) / len);
      plane_norm[p][i] = int'(raw[i] < 0 ? -n : n);
    end
    q = m[3] / len;
    rem = m[3] % len;
    if (q > (DistLim >> FracBits)) begin
      dmag = DistLim;
    end else begin
      dmag = (q << FracBits) + ((rem << FracBits) / len);
      if (dmag > DistLim) dmag = DistLim;
    end
    plane_ofs[p] = raw[3] < 0 ? -longint'(dmag) : longint'(dmag);
    plane_flat[p] = 1'b0;
  endfunction

  // Right, left, bottom, top, far from column four; near from column three
  function automatic void extract_frustum();
    int     col [NumPlanes] = '{0, 0, 1, 1, 2, 2};
    int     sgn [NumPlanes] = '{-1, 1, 1, -1, -1, 0};
    quad_t  raw;
    longint a, b;
    for (int p = 0; p < NumPlanes; p++) begin
      for (int k = 0; k < 4; k++) begin
        a = clip_cells[k * 4 + 3];
        b = clip_cells[k * 4 + col[p]];
        raw[k] = sgn[p] == 0 ? b : (sgn[p] > 0 ? a + b : a - b);
      end
      build_frustum_plane(p, raw);
    end
  endfunction

  function automatic bit sphere_in_view(longint cx, longint cy, longint cz, longint r);
    longint s, q, rem, k;
    for (int p = 0; p < NumPlanes; p++) begin
      if (plane_flat[p]) continue;
      s = longint'(plane_norm[p][0]) * cx + longint'(plane_norm[p][1]) * cy
        + longint'(plane_norm[p][2]) * cz;
      q = s >= 0 ? s / Unit : -((-s + Unit - 1) / Unit);
      rem = s - q * Unit;
      k = -(plane_ofs[p] + r);
      if (q < k || (q == k && rem == 0)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the predictor by one accepted item
  function automatic void predict_item(cmd_t c);
    case (c.op)
      OP_WRITE_ROW: for (int i = 0; i < 4; i++) clip_cells[c.row * 4 + i] = int'(c.elem[i]);
      OP_EXTRACT:   extract_frustum();
      OP_SPHERE:    visible_q.push_back(sphere_in_view(longint'(signed'(c.cx)),
                      longint'(signed'(c.cy)), longint'(signed'(c.cz)), longint'(c.rad)));
      default: ;
    endcase
  endfunction

  // Send one item, hold start high until accepted
  task automatic send_item(cmd_t c);
    start       <= 1'b1;
    op_i        <= c.op;
    row_index_i <= c.row;
    row_elem_0_i <= c.elem[0];
    row_elem_1_i <= c.elem[1];
    row_elem_2_i <= c.elem[2];
    row_elem_3_i <= c.elem[3];
    center_x_i  <= c.cx;
    center_y_i  <= c.cy;
    center_z_i  <= c.cz;
    radius_i    <= c.rad;
    do @(posedge clk_i); while (busy);
    predict_item(c);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_value(int spread);
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom();
      3:       return 32'd0;
      default: return 32'($signed($urandom_range(2 * spread)) - spread);
    endcase
  endfunction

  function automatic cmd_t blank_cmd(logic [1:0] op);
    cmd_t c;
    c.op = op;
    c.row = 2'd0;
    for (int i = 0; i < 4; i++) c.elem[i] = '0;
    c.cx = '0;
    c.cy = '0;
    c.cz = '0;
    c.rad = '0;
    return c;
  endfunction

  function automatic cmd_t row_cmd(int r, int e0, int e1, int e2, int e3);
    cmd_t c;
    c = blank_cmd(OP_WRITE_ROW);
    c.row = 2'(r);
    c.elem = '{e0, e1, e2, e3};
    return c;
  endfunction

  function automatic cmd_t sphere_cmd(int x, int y, int z, logic [30:0] r);
    cmd_t c;
    c = blank_cmd(OP_SPHERE);
    c.cx = x;
    c.cy = y;
    c.cz = z;
    c.rad = r;
    return c;
  endfunction

  function automatic cmd_t random_sphere();
    cmd_t c;
    c = sphere_cmd(pick_value(1 << 21), pick_value(1 << 21), pick_value(1 << 21), '0);
    c.rad = $urandom_range(3) == 0 ? 31'($urandom()) : 31'($urandom_range(1 << 19));
    return c;
  endfunction

  // Hold off until every expected result has arrived
  task automatic drain();
    start <= 1'b0;
    while (visible_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    send_item(sphere_cmd(0, 0, 0, '0));
    send_item(sphere_cmd(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff));
    // Extract from an all-zero matrix: every plane stays degenerate
    send_item(blank_cmd(OP_EXTRACT));
    send_item(sphere_cmd(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0));
  endtask

  task automatic test_directed();
    cmd_t c;
    // Identity view box, cull outside and keep inside
    for (int r = 0; r < 4; r++)
      send_item(row_cmd(r, r == 0 ? 65536 : 0, r == 1 ? 65536 : 0,
                        r == 2 ? 65536 : 0, r == 3 ? 65536 : 0));
    send_item(blank_cmd(OP_EXTRACT));
    send_item(sphere_cmd(0, 0, 32768, 31'd0));
    send_item(sphere_cmd(3 << 16, 0, 32768, 31'd65536));
    send_item(sphere_cmd(2 << 16, 0, 32768, 31'd65536));
    send_item(sphere_cmd(0, 0, -(1 << 16), 31'd65536));
    // Matrix write after extraction leaves planes alone
    send_item(row_cmd(3, 0, 0, 0, 0));
    send_item(sphere_cmd(3 << 16, 0, 32768, 31'd0));
    c = blank_cmd(OpUnused);
    c.cx = 32'hffff_ffff;
    send_item(c);
    // Extreme matrix values
    send_item(row_cmd(0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
    send_item(row_cmd(1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_item(row_cmd(2, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_item(row_cmd(3, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000));
    send_item(blank_cmd(OP_EXTRACT));
    send_item(sphere_cmd(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '0));
    send_item(sphere_cmd(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0));
    send_item(sphere_cmd(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff));
    drain();
  endtask

  task automatic test_random(int count);
    cmd_t c;
    int   spread;
    int   sent;
    sent = 0;
    while (sent < count) begin
      // Frame: four rows, extraction in most frames, then a run of mostly sphere tests
      spread = $urandom_range(1) ? (1 << 17) : (1 << 30);
      for (int r = 0; r < 4; r++) begin
        send_item(row_cmd(r, pick_value(spread), pick_value(spread),
                          pick_value(spread), pick_value(spread)));
        sent++;
      end
      if ($urandom_range(9) != 0) begin
        send_item(blank_cmd(OP_EXTRACT));
        sent++;
      end
      repeat ($urandom_range(20, 60)) begin
        case ($urandom_range(19))
          0: begin
            c = blank_cmd(OpUnused);
            c.cx = $urandom();
            send_item(c);
          end
          1: begin
            c = row_cmd($urandom_range(3), $urandom(), $urandom(), $urandom(), $urandom());
            send_item(c);
            sent++;
          end
          default: begin
            send_item(random_sphere());
            sent++;
          end
        endcase
      end
    end
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (visible_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: visible %0b", visible_o);
      end else begin
        bit exp_vis;
        exp_vis = visible_q.pop_front();
        if (visible_o !== exp_vis) begin
          mismatches++;
          if (mismatches <= 10) $display("visible mismatch: expected %0b actual %0b",
                                         exp_vis, visible_o);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item or result
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IdleLimit) begin
      $display("frustum_sphere_cull_unit regression: fail");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    cmd_t c;
    c = blank_cmd(OP_WRITE_ROW);
    mismatches = 0;
    idle_cnt   = 0;
    idle_pct   = 20;
    rst_ni     = 1'b0;
    start      = 1'b0;
    op_i       = c.op;
    row_index_i = '0;
    row_elem_0_i = '0;
    row_elem_1_i = '0;
    row_elem_2_i = '0;
    row_elem_3_i = '0;
    center_x_i = '0;
    center_y_i = '0;
    center_z_i = '0;
    radius_i   = '0;
    for (int i = 0; i < 16; i++) clip_cells[i] = 0;
    for (int p = 0; p < NumPlanes; p++) begin
      plane_norm[p] = '{0, 0, 0};
      plane_ofs[p]  = 0;
      plane_flat[p] = 1'b1;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_directed();
    idle_pct = 20;
    test_random(320);
    idle_pct = 46;
    test_random(320);
    idle_pct = 0;
    test_random(310);

    drain();
    if (mismatches == 0 && visible_q.size() == 0) begin
      $display("frustum_sphere_cull_unit regression: pass");
    end else begin
      $display("frustum_sphere_cull_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
